// ===== hw/rtl/aip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

    // Default sizes of the value datapath and the index counter.
    localparam int DefValueWidth = 32;
    localparam int DefMaxChars   = 255;

    // Field and register widths.
    localparam int CharW     = 8;
    localparam int BaseW     = 6;
    localparam int DigitW    = 5;
    localparam int ResultW   = 32;
    localparam int StopW     = 8;
    localparam int ApbAddrW  = 3;
    localparam int ApbDataW  = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    // Register reset values.
    localparam logic [BaseW-1:0] RST_NUMBER_BASE = 6'd10;
    localparam logic             RST_SIGNED_MODE = 1'b1;

    // Radix values used by the prefix logic.
    localparam logic [BaseW-1:0] BASE_AUTO = 6'd0;
    localparam logic [BaseW-1:0] BASE_OCT  = 6'd8;
    localparam logic [BaseW-1:0] BASE_DEC  = 6'd10;
    localparam logic [BaseW-1:0] BASE_HEX  = 6'd16;

    // Character codes.
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_NINE  = 8'h39;
    localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CH_X_LO  = 8'h78;
    localparam logic [CharW-1:0] CH_X_UP  = 8'h58;
    localparam logic [CharW-1:0] CH_A_LO  = 8'h61;
    localparam logic [CharW-1:0] CH_F_LO  = 8'h66;
    localparam logic [CharW-1:0] CH_A_UP  = 8'h41;
    localparam logic [CharW-1:0] CH_F_UP  = 8'h46;

    // Marks a character that is not a digit at all.
    localparam logic [DigitW-1:0] DIGIT_NONE = 5'h1F;

    // Parse phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_ZERO_AUTO,
        PH_HELD_X,
        PH_ZERO_HEX,
        PH_DIGITS
    } t_phase;

    // Digit value of a character, DIGIT_NONE when it is not 0-9, a-f or A-F.
    function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
        logic [CharW-1:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            d = c - CH_A_LO + 8'd10;
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            d = c - CH_A_UP + 8'd10;
        end else begin
            d = {3'b000, DIGIT_NONE};
        end
        return d[DigitW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ascii_integer_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// ASCII integer parser. Characters arrive one per transaction, and a
// transaction with i_string_start high begins a new string. The block takes
// one character in every clock cycle in which o_in_ready is high: the phase,
// the accumulator update (accumulator times a 6-bit radix plus the digit)
// and the index count are all settled in the cycle the character is
// accepted, and a result is held in an output register. o_in_ready is high
// whenever that register is empty or is being emptied in the same cycle, so
// a full stream runs at one character per clock while results are taken,
// with each result appearing in the cycle after its stopping character. The
// longest path is the VALUE_WIDTH by 6-bit multiply-add. Register 0 (address
// 0) holds the radix, 0 for automatic detection; register 1 (address 4)
// enables a leading minus sign. Both are sampled when a string starts.
module ascii_integer_parser_top #(
    parameter int VALUE_WIDTH = aip_pkg::DefValueWidth,
    parameter int MAX_CHARS   = aip_pkg::DefMaxChars
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Character channel.
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic [aip_pkg::CharW-1:0]     i_char_code,
    input  wire logic                          i_string_start,
    // Result channel.
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic [aip_pkg::ResultW-1:0]   o_parsed_value,
    output      logic [aip_pkg::StopW-1:0]     o_stop_index,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aip_pkg::ApbAddrW-1:0]  paddr,
    input  wire logic [aip_pkg::ApbDataW-1:0]  pwdata,
    output      logic [aip_pkg::ApbDataW-1:0]  prdata,
    output      logic                          pready
);
    import aip_pkg::*;

    localparam int IdxW  = $clog2(MAX_CHARS + 1);
    localparam int ProdW = VALUE_WIDTH + BaseW;

    // Configuration registers.
    logic [BaseW-1:0]       r_number_base;
    logic                   r_signed_mode;

    // Parse state.
    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [BaseW-1:0]       r_base, n_base;
    logic [IdxW-1:0]        r_idx, n_idx;
    logic                   r_neg, n_neg;

    // Result register.
    logic                   r_out_valid, n_out_valid;
    logic [ResultW-1:0]     r_value, n_value;
    logic [StopW-1:0]       r_stop, n_stop;

    logic                   in_fire;
    logic                   cfg_write;
    logic [DigitW-1:0]      digit;
    logic [ProdW-1:0]       mac;
    logic [VALUE_WIDTH-1:0] signed_val;
    logic [IdxW+7:0]        idx_ext;

    function automatic logic [IdxW-1:0] bump(input logic [IdxW-1:0] idx);
        return (idx < IdxW'(MAX_CHARS)) ? IdxW'(idx + 1'b1) : idx;
    endfunction

    // Handshake and configuration decode.
    always_comb begin
        o_in_ready = !r_out_valid || i_out_ready;
        in_fire    = i_in_valid && o_in_ready;
        pready     = 1'b1;
        cfg_write  = psel && penable && pwrite;
        unique case (paddr[2])
            REG_NUMBER_BASE: prdata = {{(ApbDataW-BaseW){1'b0}}, r_number_base};
            REG_SIGNED_MODE: prdata = {{(ApbDataW-1){1'b0}}, r_signed_mode};
            default:         prdata = '0;
        endcase
    end

    assign digit = digit_of(i_char_code);

    // Next parse state for the accepted character.
    always_comb begin
        logic take;
        logic fin;
        logic skip;
        logic is_x;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_base      = r_base;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value     = r_value;
        n_stop      = r_stop;
        take        = 1'b0;
        fin         = 1'b0;
        skip        = 1'b0;
        is_x        = (i_char_code == CH_X_LO) || (i_char_code == CH_X_UP);
        mac         = '0;
        signed_val  = '0;
        idx_ext     = '0;

        if (in_fire) begin
            // A string start loads the configuration and may take a sign.
            if (i_string_start) begin
                n_acc   = '0;
                n_base  = r_number_base;
                n_idx   = '0;
                n_neg   = 1'b0;
                n_phase = PH_PREFIX;
                if (r_signed_mode && i_char_code == CH_MINUS) begin
                    n_neg = 1'b1;
                    n_idx = bump(n_idx);
                    skip  = 1'b1;
                end
            end

            if (!skip) begin
                unique case (n_phase)
                    PH_PREFIX: begin
                        if (n_base == BASE_AUTO) begin
                            if (i_char_code == CH_ZERO) begin
                                n_base  = BASE_OCT;
                                n_idx   = bump(n_idx);
                                n_phase = PH_ZERO_AUTO;
                            end else begin
                                n_base = BASE_DEC;
                                take   = 1'b1;
                            end
                        end else if (n_base == BASE_HEX && i_char_code == CH_ZERO) begin
                            n_idx   = bump(n_idx);
                            n_phase = PH_ZERO_HEX;
                        end else begin
                            take = 1'b1;
                        end
                    end
                    PH_ZERO_AUTO: begin
                        if (is_x) begin
                            n_phase = PH_HELD_X;
                        end else begin
                            take = 1'b1;
                        end
                    end
                    PH_HELD_X: begin
                        // The held x becomes a hex prefix only before a hex digit.
                        if (digit != DIGIT_NONE) begin
                            n_base = BASE_HEX;
                            n_idx  = bump(n_idx);
                            take   = 1'b1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    PH_ZERO_HEX: begin
                        if (is_x) begin
                            n_idx   = bump(n_idx);
                            n_phase = PH_DIGITS;
                        end else begin
                            take = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        take = 1'b1;
                    end
                    PH_IDLE: begin
                    end
                    default: begin
                    end
                endcase
            end

            // Digit accumulation, shared by every phase that takes a digit.
            mac = ProdW'(n_acc) * ProdW'(n_base) + ProdW'(digit);
            if (take) begin
                n_phase = PH_DIGITS;
                if (digit != DIGIT_NONE && {1'b0, digit} < n_base) begin
                    n_acc = mac[VALUE_WIDTH-1:0];
                    n_idx = bump(n_idx);
                end else begin
                    fin = 1'b1;
                end
            end

            // The stopping character loads the result register.
            signed_val = n_neg ? VALUE_WIDTH'(~n_acc + 1'b1) : n_acc;
            idx_ext    = (IdxW+8)'(n_idx);
            if (fin) begin
                n_phase     = PH_IDLE;
                n_out_valid = 1'b1;
                n_value     = ResultW'(signed_val);
                n_stop      = (idx_ext > (IdxW+8)'(255)) ? 8'hFF : idx_ext[7:0];
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= RST_NUMBER_BASE;
            r_signed_mode <= RST_SIGNED_MODE;
            r_phase       <= PH_IDLE;
            r_acc         <= '0;
            r_base        <= '0;
            r_idx         <= '0;
            r_neg         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_NUMBER_BASE: r_number_base <= pwdata[BaseW-1:0];
                    REG_SIGNED_MODE: r_signed_mode <= pwdata[0];
                    default: begin
                    end
                endcase
            end
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_base      <= n_base;
            r_idx       <= n_idx;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_stop  <= n_stop;
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_value;
    assign o_stop_index   = r_stop;

endmodule

`default_nettype wire

// ===== hw/rtl/aip_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aip_checker #(
    parameter int MAX_CHARS = aip_pkg::DefMaxChars
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [aip_pkg::ResultW-1:0]   o_parsed_value,
    input wire logic [aip_pkg::StopW-1:0]     o_stop_index
);
    import aip_pkg::*;

    localparam int StopMax = (MAX_CHARS > 255) ? 255 : MAX_CHARS;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A pending result holds with its payload until the transaction.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_parsed_value) && $stable(o_stop_index)))
        else $error("result dropped or changed while stalled");

    // A result only appears after a character transaction.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without a character");

    // Characters are taken whenever the result register is free.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with free result register");

    // The stop index never passes the index limit.
    a_stop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_stop_index) <= 32'(StopMax)))
        else $error("stop index beyond limit");

endmodule

bind ascii_integer_parser_top aip_checker #(
    .MAX_CHARS(MAX_CHARS)
) u_aip_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_parsed_value (o_parsed_value),
    .o_stop_index   (o_stop_index)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import aip_pkg::*;

    // Tracks the parse of the character stream and holds the results it predicts.
    class parse_scoreboard;
        typedef struct packed {
            logic [ResultW-1:0] value;
            logic [StopW-1:0]   index;
        } t_parse_result;

        t_parse_result            expected_numbers[$];
        int unsigned              failures;
        logic [BaseW-1:0]         base_reg;
        logic                     sign_reg;
        t_phase                   stage;
        logic [DefValueWidth-1:0] acc;
        logic [BaseW-1:0]         radix;
        int unsigned              char_count;
        logic                     negative;

        function new();
            failures   = 0;
            base_reg   = RST_NUMBER_BASE;
            sign_reg   = RST_SIGNED_MODE;
            stage      = PH_IDLE;
            acc        = '0;
            radix      = '0;
            char_count = 0;
            negative   = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_numbers.size();
        endfunction

        function void set_register(logic idx, logic [ApbDataW-1:0] data);
            if (idx == REG_NUMBER_BASE) begin
                base_reg = data[BaseW-1:0];
            end else begin
                sign_reg = data[0];
            end
        endfunction

        // Digit value of a hex character, -1 for anything else.
        function int hex_value(logic [CharW-1:0] c);
            if (c >= "0" && c <= "9") begin
                return int'(c) - int'("0");
            end else if (c >= "a" && c <= "f") begin
                return int'(c) - int'("a") + 10;
            end else if (c >= "A" && c <= "F") begin
                return int'(c) - int'("A") + 10;
            end
            return -1;
        endfunction

        function void bump();
            if (char_count < DefMaxChars) begin
                char_count++;
            end
        endfunction

        function void finish_parse();
            t_parse_result            r;
            logic [DefValueWidth-1:0] v;
            v = negative ? -acc : acc;
            r.value = ResultW'(v);
            r.index = (char_count > 255) ? 8'd255 : 8'(char_count);
            expected_numbers.push_back(r);
            stage = PH_IDLE;
        endfunction

        function void take_digit(logic [CharW-1:0] c);
            int d;
            d = hex_value(c);
            stage = PH_DIGITS;
            if (d >= 0 && d < int'(radix)) begin
                acc = acc * radix + d;
                bump();
            end else begin
                finish_parse();
            end
        endfunction

        // Advances the parse by one accepted character.
        function void note_char(logic [CharW-1:0] c, logic start);
            if (start) begin
                acc        = '0;
                radix      = base_reg;
                char_count = 0;
                negative   = 1'b0;
                stage      = PH_PREFIX;
                if (sign_reg && c == CH_MINUS) begin
                    negative = 1'b1;
                    bump();
                    return;
                end
            end
            case (stage)
                PH_PREFIX: begin
                    if (radix == BASE_AUTO) begin
                        if (c == CH_ZERO) begin
                            radix = BASE_OCT;
                            bump();
                            stage = PH_ZERO_AUTO;
                        end else begin
                            radix = BASE_DEC;
                            take_digit(c);
                        end
                    end else if (radix == BASE_HEX && c == CH_ZERO) begin
                        bump();
                        stage = PH_ZERO_HEX;
                    end else begin
                        take_digit(c);
                    end
                end
                PH_ZERO_AUTO: begin
                    if (c == CH_X_LO || c == CH_X_UP) begin
                        stage = PH_HELD_X;
                    end else begin
                        take_digit(c);
                    end
                end
                PH_HELD_X: begin
                    // The held x is consumed only when a hex digit follows it.
                    if (hex_value(c) >= 0) begin
                        radix = BASE_HEX;
                        bump();
                        take_digit(c);
                    end else begin
                        finish_parse();
                    end
                end
                PH_ZERO_HEX: begin
                    if (c == CH_X_LO || c == CH_X_UP) begin
                        bump();
                        stage = PH_DIGITS;
                    end else begin
                        take_digit(c);
                    end
                end
                PH_DIGITS: begin
                    take_digit(c);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [ResultW-1:0] value, logic [StopW-1:0] index);
            t_parse_result want;
            if (expected_numbers.size() == 0) begin
                $error("unexpected result: parsed_value %h, stop_index %0d", value, index);
                failures++;
                return;
            end
            want = expected_numbers.pop_front();
            if (value !== want.value) begin
                $error("parsed_value: expected %h, actual %h", want.value, value);
                failures++;
            end
            if (index !== want.index) begin
                $error("stop_index: expected %0d, actual %0d", want.index, index);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [CharW-1:0]    i_char_code;
    logic                i_string_start;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [ResultW-1:0]  o_parsed_value;
    logic [StopW-1:0]    o_stop_index;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    parse_scoreboard sb = new();
    bit              no_idle;
    bit              first_char;
    int unsigned     items;

    ascii_integer_parser_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_string_start (i_string_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_parsed_value (o_parsed_value),
        .o_stop_index   (o_stop_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** ascii_integer_parser_top: FAILED **");
        $finish;
    end

    function automatic bit take_break();
        return !no_idle && ($urandom_range(0, 99) < 36);
    endfunction

    // Result side: ready drops at random unless the idle-free stretch is on.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= !take_break();
        end
    end

    // Every accepted transaction on either channel goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_parsed_value, o_stop_index);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_char(i_char_code, i_string_start);
            end
        end
    end

    task automatic send_char(input logic [CharW-1:0] c, input logic start);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_code    <= c;
        i_string_start <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Sends one character of the current string; the first one carries the start flag.
    task automatic emit(input logic [CharW-1:0] c);
        send_char(c, first_char);
        first_char = 1'b0;
        items++;
    endtask

    task automatic send_text(input string txt);
        first_char = 1'b1;
        for (int i = 0; i < txt.len(); i++) begin
            emit(txt[i]);
        end
    endtask

    // Waits until every expected result has arrived and the block has settled.
    // The first edge lets the monitor note the last accepted character.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ApbDataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, data);
    endtask

    // Upper data bits are junk that the registers must drop.
    task automatic configure(input logic [BaseW-1:0] base, input logic sgn);
        write_reg(REG_NUMBER_BASE, ($urandom() & 32'hFFFF_FFC0) | 32'(base));
        write_reg(REG_SIGNED_MODE, ($urandom() & 32'hFFFF_FFFE) | 32'(sgn));
    endtask

    function automatic logic [CharW-1:0] digit_char(input int d);
        if (d < 10) begin
            return CH_ZERO + 8'(d);
        end else if ($urandom_range(0, 1) != 0) begin
            return CH_A_LO + 8'(d - 10);
        end
        return CH_A_UP + 8'(d - 10);
    endfunction

    // One random string: mostly well formed, some noise and abandoned strings.
    task automatic gen_string(input logic [BaseW-1:0] base, input logic sgn);
        int kind;
        int eff;
        int lim;
        int ndig;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            items++;
            return;
        end
        if (kind < 12) begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        first_char = 1'b1;
        if (sgn && $urandom_range(0, 2) == 0) begin
            emit(CH_MINUS);
        end
        eff = int'(base);
        if ((base == BASE_AUTO || base == BASE_HEX) && $urandom_range(0, 1) != 0) begin
            emit(CH_ZERO);
            if ($urandom_range(0, 3) != 0) begin
                emit($urandom_range(0, 1) != 0 ? CH_X_LO : CH_X_UP);
                eff = 16;
            end else if (base == BASE_AUTO) begin
                eff = 8;
            end
        end else if (base == BASE_AUTO) begin
            eff = 10;
        end
        lim  = (eff > 16) ? 16 : eff;
        ndig = ($urandom_range(0, 79) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 12);
        for (int k = 0; k < ndig; k++) begin
            emit(digit_char($urandom_range(0, lim - 1)));
        end
        // Some strings are cut short and get abandoned by the next start.
        if ($urandom_range(0, 9) == 0) begin
            return;
        end
        if (lim < 16 && $urandom_range(0, 1) != 0) begin
            emit(digit_char($urandom_range(lim, 15)));
        end else begin
            emit(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [BaseW-1:0] pick_base();
        case ($urandom_range(0, 9))
            0, 1:    return BASE_AUTO;
            2:       return BASE_HEX;
            3:       return BASE_DEC;
            4:       return BASE_OCT;
            5:       return 6'd2;
            6:       return 6'd1;
            7:       return 6'd36;
            8:       return 6'd63;
            default: return 6'($urandom_range(2, 63));
        endcase
    endfunction

    initial begin
        logic [BaseW-1:0] base;
        logic             sgn;
        int unsigned      target;
        int               phase_no;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_char_code    <= '0;
        i_string_start <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        no_idle        = 1'b0;
        items          = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: decimal, signed. A stray character while idle is ignored.
        send_char("5", 1'b0);
        send_text("-9");
        emit(8'hFF);
        // A new start abandons the string in flight.
        send_text("12");
        send_text("3");
        emit(8'h00);
        drain();

        // Automatic radix, unsigned: held x with and without a hex digit, octal.
        configure(BASE_AUTO, 1'b0);
        send_text("0xg");
        send_text("0XfFz");
        send_text("078");
        send_text("-");
        drain();

        // Hex skips 0x even when no digit follows.
        configure(BASE_HEX, 1'b1);
        send_text("0x-");
        drain();

        // Base one takes only zeros; the widest base still takes only hex digits.
        configure(6'd1, 1'b0);
        send_text("01");
        drain();
        configure(6'd63, 1'b1);
        send_text("Fz");
        drain();

        // Random phases, each under its own settings.
        items    = 0;
        phase_no = 0;
        while (items < 1500) begin
            base = pick_base();
            sgn  = 1'($urandom_range(0, 1));
            configure(base, sgn);
            no_idle = (phase_no == 2) || ($urandom_range(0, 5) == 0);
            target  = items + 100;
            while (items < target) begin
                gen_string(base, sgn);
            end
            drain();
            no_idle = 1'b0;
            phase_no++;
        end

        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("** ascii_integer_parser_top: PASSED **");
        end else begin
            $display("** ascii_integer_parser_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/aip_pkg.sv
hw/rtl/ascii_integer_parser_top.sv
hw/rtl/aip_checker.sv
tb/tb.sv
